@@ hdl/skrt_pkg.sv @@
// Shared types and constants for the sorted key route table.
package skrt_pkg;

  localparam int unsigned DefTableDepth = 64;
  localparam int unsigned DefNodeWidth  = 48;
  localparam int unsigned KeyWidth      = 32;
  localparam int unsigned IdxWidth      = 32;
  localparam int unsigned PosWidth      = 6;
  localparam int unsigned ReqWidth      = 3;

  localparam logic [ReqWidth-1:0] REQ_INSERT   = 3'd0;
  localparam logic [ReqWidth-1:0] REQ_REMOVE   = 3'd1;
  localparam logic [ReqWidth-1:0] REQ_LOOKUP   = 3'd2;
  localparam logic [ReqWidth-1:0] REQ_POS_KEY  = 3'd3;
  localparam logic [ReqWidth-1:0] REQ_POS_NODE = 3'd4;
  localparam logic [ReqWidth-1:0] REQ_MATCH    = 3'd5;

  // Datapath command from the controller.
  typedef struct packed {
    logic load;      // capture request fields, clear pointer
    logic scan_inc;  // advance pointer
    logic pos_hit;   // found position <= pointer - 1
    logic pos_end;   // found position <= pointer
    logic mod_init;  // start modulo reduction
    logic mod_step;  // one bit of modulo reduction
    logic mod_rd;    // read at remainder
    logic shift_up;  // read entry at pointer - 1
    logic shift_dn;  // read entry at pointer + 1
    logic move_wr;   // write read data at pointer
    logic put_new;   // write new key/node at pointer
    logic ptr_dec;   // move pointer down
    logic cnt_inc;
    logic cnt_dec;
    logic ptr_set_cnt; // pointer <= count
    logic res_fail;
    logic res_ok;
  } skrt_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic scan_done;   // scan pointer reached count
    logic key_eq;      // read key equals request key
    logic node_eq;
    logic key_lt;      // read key < request key (insert spot)
    logic cnt_zero;
    logic cnt_full;
    logic mod_done;
    logic ptr_at_pos;  // pointer equals found position
    logic ptr_at_end;  // pointer+1 >= count
  } skrt_stat_t;

endpackage

@@ hdl/skrt_ram.sv @@
// Generic single-port write, single-port registered-read RAM.
module skrt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/skrt_datapath.sv @@
// Datapath: table memories, scan pointer, modulo unit and result registers.
module skrt_datapath #(
  parameter int unsigned TableDepth = skrt_pkg::DefTableDepth,
  parameter int unsigned NodeWidth  = skrt_pkg::DefNodeWidth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  skrt_pkg::skrt_cmd_t           cmd,
  output skrt_pkg::skrt_stat_t          stat,
  input  logic [skrt_pkg::ReqWidth-1:0] in_req_type,
  input  logic [skrt_pkg::KeyWidth-1:0] in_key,
  input  logic [NodeWidth-1:0]          in_node,
  input  logic [skrt_pkg::IdxWidth-1:0] in_index,
  output logic [skrt_pkg::ReqWidth-1:0] req_type,
  output logic                          out_status,
  output logic [NodeWidth-1:0]          out_node_out,
  output logic [skrt_pkg::PosWidth-1:0] out_position,
  output logic                          out_matched
);
  import skrt_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned MW = KeyWidth;

  logic [ReqWidth-1:0] req_r;
  logic [KeyWidth-1:0] key_r;
  logic [NodeWidth-1:0] node_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] ptr_r;      // scan / shift pointer
  logic [AW-1:0] pos_r;      // found position
  // modulo
  logic [MW-1:0] dvd_r;
  logic [CW-1:0] rem_r;
  logic [5:0]    mbit_r;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_sub;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  logic [KeyWidth-1:0]  kw;
  logic [NodeWidth-1:0] nw;
  logic [KeyWidth-1:0]  kr;
  logic [NodeWidth-1:0] nr;
  logic [CW-1:0] ptr_p1;

  assign req_type = req_r;
  assign ptr_p1   = ptr_r + CW'(1);

  assign rem_sh  = {rem_r, dvd_r[MW-1]};
  assign rem_sub = rem_sh - {1'b0, cnt_r};

  always_comb begin
    raddr = ptr_r[AW-1:0];
    if (cmd.mod_rd) begin
      raddr = rem_r[AW-1:0];
    end else if (cmd.shift_up) begin
      raddr = AW'(ptr_r - CW'(1));
    end else if (cmd.shift_dn) begin
      raddr = AW'(ptr_p1);
    end
  end

  // Moves write the entry read in the previous step (at p-1 or p+1).
  always_comb begin
    we    = cmd.move_wr | cmd.put_new;
    waddr = ptr_r[AW-1:0];
    kw    = cmd.put_new ? key_r  : kr;
    nw    = cmd.put_new ? node_r : nr;
  end

  skrt_ram #(.Width(KeyWidth), .Depth(TableDepth)) u_key_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(kw), .raddr(raddr), .rdata(kr)
  );
  skrt_ram #(.Width(NodeWidth), .Depth(TableDepth)) u_node_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(nw), .raddr(raddr), .rdata(nr)
  );

  always_comb begin
    stat.scan_done  = (ptr_r >= cnt_r);
    stat.key_eq     = (kr == key_r);
    stat.node_eq    = (nr == node_r);
    stat.key_lt     = (kr < key_r);
    stat.cnt_zero   = (cnt_r == '0);
    stat.cnt_full   = (cnt_r == CW'(TableDepth));
    stat.mod_done   = (mbit_r == '0);
    stat.ptr_at_pos = (ptr_r[AW-1:0] == pos_r) && (ptr_r < CW'(TableDepth));
    stat.ptr_at_end = (ptr_p1 >= cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      key_r  <= in_key;
      node_r <= in_node;
      dvd_r  <= (in_req_type == REQ_MATCH) ? in_index : in_key;
      ptr_r  <= '0;
    end else begin
      if (cmd.scan_inc) begin
        ptr_r <= ptr_p1;
      end else if (cmd.ptr_set_cnt) begin
        ptr_r <= cnt_r;
      end else if (cmd.ptr_dec) begin
        ptr_r <= ptr_r - CW'(1);
      end
      if (cmd.mod_step) begin
        dvd_r <= {dvd_r[MW-2:0], 1'b0};
      end
    end
    // Latch found position: a hit read its data at ptr-1, an append uses ptr itself.
    if (cmd.pos_hit) begin
      pos_r <= AW'(ptr_r - CW'(1));
    end else if (cmd.pos_end) begin
      pos_r <= AW'(ptr_r);
    end
    if (cmd.mod_init) begin
      rem_r  <= '0;
      mbit_r <= 6'(MW);
    end else if (cmd.mod_step) begin
      mbit_r <= mbit_r - 6'd1;
      rem_r  <= rem_sub[CW] ? rem_sh[CW-1:0] : rem_sub[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_fail || cmd.res_ok) begin
      out_status   <= cmd.res_fail;
      out_node_out <= (cmd.res_ok && req_r == REQ_LOOKUP) ? nr : '0;
      out_position <= (cmd.res_ok && (req_r == REQ_POS_KEY || req_r == REQ_POS_NODE))
                      ? PosWidth'(pos_r) : '0;
      out_matched  <= (cmd.res_ok && req_r == REQ_MATCH) ? (kr == key_r) : 1'b0;
    end
  end
endmodule

@@ hdl/skrt_ctrl.sv @@
// Controller state machine for the route table.
module skrt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  output logic                          out_valid,
  input  logic [skrt_pkg::ReqWidth-1:0] req_type,
  input  skrt_pkg::skrt_stat_t          stat,
  output skrt_pkg::skrt_cmd_t           cmd
);
  import skrt_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DISP   = 12'b000000000010,
    S_SCAN   = 12'b000000000100,
    S_CHK    = 12'b000000001000,
    S_MOD    = 12'b000000010000,
    S_MODRD  = 12'b000000100000,
    S_MODCHK = 12'b000001000000,
    S_UPRD   = 12'b000010000000,
    S_UPWR   = 12'b000100000000,
    S_DNRD   = 12'b001000000000,
    S_DNWR   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ok_r, ok_nxt;
  logic   vld_r, vld_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ok_r    <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    vld_nxt   = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (req_type)
          REQ_INSERT: begin
            if (stat.cnt_full) begin
              ok_nxt    = 1'b0;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          REQ_REMOVE, REQ_POS_KEY, REQ_POS_NODE: begin
            state_nxt = S_SCAN;
          end
          REQ_LOOKUP, REQ_MATCH: begin
            if (stat.cnt_zero) begin
              ok_nxt    = 1'b0;
              state_nxt = S_DONE;
            end else begin
              cmd.mod_init = 1'b1;
              state_nxt    = S_MOD;
            end
          end
          default: begin
            ok_nxt    = 1'b0;
            state_nxt = S_DONE;
          end
        endcase
      end
      // Read entry at pointer, advance; check the data next cycle.
      S_SCAN: begin
        if (stat.scan_done) begin
          if (req_type == REQ_INSERT) begin
            // No smaller key found: append at the end.
            cmd.pos_end     = 1'b1;
            cmd.ptr_set_cnt = 1'b1;
            state_nxt       = S_UPRD;
          end else begin
            ok_nxt    = 1'b0;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_CHK;
        end
      end
      S_CHK: begin
        if (req_type == REQ_POS_NODE ? stat.node_eq : stat.key_eq) begin
          cmd.pos_hit = 1'b1;
          if (req_type == REQ_INSERT) begin
            ok_nxt    = 1'b0;
            state_nxt = S_DONE;
          end else if (req_type == REQ_REMOVE) begin
            cmd.ptr_dec = 1'b1;
            state_nxt   = S_DNRD;
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = S_DONE;
          end
        end else if (req_type == REQ_INSERT && stat.key_lt) begin
          // First smaller key: the new entry goes in its place.
          cmd.pos_hit     = 1'b1;
          cmd.ptr_set_cnt = 1'b1;
          state_nxt       = S_UPRD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_nxt = S_MODRD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_MODRD: begin
        cmd.mod_rd = 1'b1;
        state_nxt  = S_MODCHK;
      end
      S_MODCHK: begin
        cmd.res_ok = 1'b1;
        vld_nxt    = 1'b1;
        state_nxt  = S_IDLE;
      end
      // Pointer walks down from count to the insert spot.
      S_UPRD: begin
        if (stat.ptr_at_pos) begin
          cmd.put_new = 1'b1;
          cmd.cnt_inc = 1'b1;
          ok_nxt      = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.shift_up = 1'b1;
          state_nxt    = S_UPWR;
        end
      end
      S_UPWR: begin
        cmd.move_wr = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_nxt   = S_UPRD;
      end
      // Remove: pointer walks up from the hit, closing the gap.
      S_DNRD: begin
        if (stat.ptr_at_end) begin
          cmd.cnt_dec = 1'b1;
          ok_nxt      = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.shift_dn = 1'b1;
          state_nxt    = S_DNWR;
        end
      end
      S_DNWR: begin
        cmd.move_wr  = 1'b1;
        cmd.scan_inc = 1'b1;
        state_nxt    = S_DNRD;
      end
      S_DONE: begin
        cmd.res_fail = !ok_r;
        cmd.res_ok   = ok_r;
        vld_nxt      = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

@@ hdl/sorted_key_route_table_core.sv @@
// Top level of the sorted key route table.
// Usage:
//   Raise start with in_req_type, in_key, in_node and in_index while busy is
//   low; the request transfers on that edge. busy stays high while the
//   request works. Exactly one result follows: out_valid is high for one
//   cycle with out_status, out_node_out, out_position and out_matched.
//   The receiver cannot stall, so each result must be taken in its cycle.
// Request paths:
//   Undefined code, insert into a full table, lookup or match on an empty
//   table: fail straight from dispatch. Lookup and match: 32-step remainder
//   unit, then one read. Key or node search, remove and insert scan the
//   entries in order; remove then shifts later entries down, insert shifts
//   entries up from the end to the insert spot and fails on a duplicate.
//   Each scanned or moved entry takes a read on the single read port.
// Request spacing:
//   busy drops in the out_valid cycle, so the next request can transfer at
//   the edge that ends it; no request is taken while one is in progress.
// Reset:
//   rst_n low empties the table (entry count to zero); memory contents
//   are not cleared and no clearing pass is needed.
// Structure:
//   skrt_ctrl sequences each request; skrt_datapath holds the key and
//   node memories, the pointers and the remainder unit.
module sorted_key_route_table_core #(
  parameter int unsigned TableDepth = skrt_pkg::DefTableDepth,
  parameter int unsigned NodeWidth  = skrt_pkg::DefNodeWidth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [skrt_pkg::ReqWidth-1:0] in_req_type,
  input  logic [skrt_pkg::KeyWidth-1:0] in_key,
  input  logic [NodeWidth-1:0]          in_node,
  input  logic [skrt_pkg::IdxWidth-1:0] in_index,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [NodeWidth-1:0]          out_node_out,
  output logic [skrt_pkg::PosWidth-1:0] out_position,
  output logic                          out_matched
);
  import skrt_pkg::*;

  skrt_cmd_t           cmd;
  skrt_stat_t          stat;
  logic [ReqWidth-1:0] req_type;

  // Sequence the request.
  skrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .req_type(req_type), .stat(stat), .cmd(cmd)
  );

  // Hold table and compute results.
  skrt_datapath #(.TableDepth(TableDepth), .NodeWidth(NodeWidth)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_req_type(in_req_type), .in_key(in_key), .in_node(in_node),
    .in_index(in_index), .req_type(req_type),
    .out_status(out_status), .out_node_out(out_node_out),
    .out_position(out_position), .out_matched(out_matched)
  );
endmodule
